FILE: sv/assert_macros.svh
// assertion helpers, sampled on the rising edge of clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDPID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sdpid_pkg.sv
`timescale 1ns / 1ps

package sdpid_pkg;

  // fixed point and field widths
  localparam int GAIN_FRAC_BITS = 16;
  localparam int CNT_W          = 32;
  localparam int CNT_FIELD_W    = 32;
  localparam int GAIN_W         = 24;
  localparam int SPD_W          = 16;
  localparam int DIST_W         = 16;
  localparam int ERR_W          = 32;

  // derived datapath widths
  localparam int SUM_W   = GAIN_W + 1;
  localparam int TGT_W   = DIST_W + GAIN_W - GAIN_FRAC_BITS;
  localparam int DLT_W   = ERR_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + DLT_W;
  localparam int CTL_W   = PROD_W + 2;
  localparam int OUT_Q_W = CTL_W + 1;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // register port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INT_LIMIT,
    REG_TICKS_PER_MM,
    REG_FWD_SPEED,
    REG_BWD_SPEED,
    REG_RIGHT_OFFSET
  } reg_idx_t;

  // what the back end has to do with one item
  typedef enum logic [1:0] {
    OP_PASS,
    OP_START,
    OP_BRAKE,
    OP_RUN
  } op_t;

  typedef struct packed {
    logic                     action;
    logic signed [DIST_W-1:0] move_mm;
    logic [CNT_FIELD_W-1:0]   left_count;
    logic [CNT_FIELD_W-1:0]   right_count;
  } cmd_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] left_motor;
    logic signed [SPD_W-1:0] right_motor;
    logic                    brake;
    logic                    moving;
  } res_t;

  typedef struct packed {
    op_t                     op;
    logic                    moving;
    logic                    going_back;
    logic signed [ERR_W-1:0] err;
  } job_t;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain_p_q16;
    logic [GAIN_W-1:0]       gain_i_dt_q16;
    logic [GAIN_W-1:0]       gain_d_over_dt_q16;
    logic [GAIN_W-1:0]       integral_limit;
    logic [GAIN_W-1:0]       ticks_per_mm_q16;
    logic signed [SPD_W-1:0] forward_speed;
    logic signed [SPD_W-1:0] backward_speed;
    logic signed [SPD_W-1:0] right_offset;
  } cfg_t;

endpackage

FILE: sv/sdpid_regs.sv
`timescale 1ns / 1ps

module sdpid_regs import sdpid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam cfg_t CFG_RESET = '{
    gain_p_q16:         GAIN_W'(78643),
    gain_i_dt_q16:      GAIN_W'(26),
    gain_d_over_dt_q16: GAIN_W'(1638400),
    integral_limit:     GAIN_W'(25000),
    ticks_per_mm_q16:   GAIN_W'(416601),
    forward_speed:      SPD_W'(700),
    backward_speed:     SPD_W'(-800),
    right_offset:       SPD_W'(100)
  };

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:       cfg.gain_p_q16         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:       cfg.gain_i_dt_q16      <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:       cfg.gain_d_over_dt_q16 <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT:    cfg.integral_limit     <= pwdata[GAIN_W-1:0];
        REG_TICKS_PER_MM: cfg.ticks_per_mm_q16   <= pwdata[GAIN_W-1:0];
        REG_FWD_SPEED:    cfg.forward_speed      <= pwdata[SPD_W-1:0];
        REG_BWD_SPEED:    cfg.backward_speed     <= pwdata[SPD_W-1:0];
        REG_RIGHT_OFFSET: cfg.right_offset       <= pwdata[SPD_W-1:0];
      endcase
    end
  end

  // read mux, speeds read back sign extended
  always_comb begin
    unique case (idx)
      REG_GAIN_P:       prdata = APB_DW'(cfg.gain_p_q16);
      REG_GAIN_I:       prdata = APB_DW'(cfg.gain_i_dt_q16);
      REG_GAIN_D:       prdata = APB_DW'(cfg.gain_d_over_dt_q16);
      REG_INT_LIMIT:    prdata = APB_DW'(cfg.integral_limit);
      REG_TICKS_PER_MM: prdata = APB_DW'(cfg.ticks_per_mm_q16);
      REG_FWD_SPEED:    prdata = APB_DW'($signed(cfg.forward_speed));
      REG_BWD_SPEED:    prdata = APB_DW'($signed(cfg.backward_speed));
      REG_RIGHT_OFFSET: prdata = APB_DW'($signed(cfg.right_offset));
    endcase
  end

endmodule

FILE: sv/sdpid_front.sv
`timescale 1ns / 1ps

module sdpid_front import sdpid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  localparam logic signed [ERR_W+1:0] ERR_MAX = (ERR_W+2)'((64'sd1 <<< (ERR_W-1)) - 1);
  localparam logic signed [ERR_W+1:0] ERR_MIN = -ERR_MAX - (ERR_W+2)'(1);

  logic                     active;
  logic                     going_back;
  logic [CNT_W-1:0]         left_origin;
  logic [CNT_W-1:0]         right_origin;
  logic [TGT_W-1:0]         goal_ticks;

  logic                     take;
  logic                     start_go;
  logic                     active_next;
  logic [DIST_W:0]          dist_ext;
  logic [DIST_W:0]          dist_neg;
  logic [DIST_W-1:0]        dist_mag;
  logic [DIST_W+GAIN_W-1:0] tgt_prod;
  logic [CNT_W-1:0]         left_travel;
  logic [CNT_W-1:0]         right_travel;
  logic [CNT_W-1:0]         left_abs;
  logic [CNT_W-1:0]         right_abs;
  logic [CNT_W:0]           travel_sum;
  logic signed [CNT_W:0]    diff;
  logic signed [ERR_W+1:0]  diff_x;
  logic signed [ERR_W-1:0]  err_sat;
  logic                     reached;
  job_t                     job_next;

  assign cmd_ready = !job_valid || job_ready;
  assign take      = cmd_valid && cmd_ready;

  // distance magnitude and target ticks
  assign dist_ext = {cmd.move_mm[DIST_W-1], cmd.move_mm};
  assign dist_neg = -dist_ext;
  assign dist_mag = cmd.move_mm[DIST_W-1] ? dist_neg[DIST_W-1:0] : dist_ext[DIST_W-1:0];
  assign tgt_prod = dist_mag * cfg.ticks_per_mm_q16;

  // wrapped wheel travel since the origins
  assign left_travel  = cmd.left_count[CNT_W-1:0] - left_origin;
  assign right_travel = cmd.right_count[CNT_W-1:0] - right_origin;
  assign left_abs     = left_travel[CNT_W-1] ? (~left_travel + 1'b1) : left_travel;
  assign right_abs    = right_travel[CNT_W-1] ? (~right_travel + 1'b1) : right_travel;
  assign travel_sum   = {1'b0, left_abs} + {1'b0, right_abs};
  // floor(sum / 2) >= target is the same as sum >= 2 * target
  assign reached      = travel_sum >= (CNT_W+1)'({goal_ticks, 1'b0});

  // left minus right, saturated to the error width
  assign diff   = $signed({left_travel[CNT_W-1], left_travel})
                - $signed({right_travel[CNT_W-1], right_travel});
  assign diff_x = (ERR_W+2)'(diff);

  always_comb begin
    if (diff_x > ERR_MAX) begin
      err_sat = ERR_MAX[ERR_W-1:0];
    end else if (diff_x < ERR_MIN) begin
      err_sat = ERR_MIN[ERR_W-1:0];
    end else begin
      err_sat = diff_x[ERR_W-1:0];
    end
  end

  // classify the item
  always_comb begin
    start_go            = 1'b0;
    active_next         = active;
    job_next.op         = OP_PASS;
    job_next.moving     = active;
    job_next.going_back = going_back;
    job_next.err        = err_sat;
    if (!cmd.action) begin
      if (cmd.move_mm != '0) begin
        start_go            = 1'b1;
        active_next         = 1'b1;
        job_next.op         = OP_START;
        job_next.moving     = 1'b1;
        job_next.going_back = cmd.move_mm[DIST_W-1];
      end
    end else if (active) begin
      if (reached) begin
        active_next     = 1'b0;
        job_next.op     = OP_BRAKE;
        job_next.moving = 1'b0;
      end else begin
        job_next.op = OP_RUN;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      going_back <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      if (take) begin
        active <= active_next;
      end
      if (take && start_go) begin
        going_back <= cmd.move_mm[DIST_W-1];
      end
      if (take) begin
        job_valid <= 1'b1;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  // move origins, target and the outgoing transaction
  always_ff @(posedge clk) begin
    if (take && start_go) begin
      left_origin  <= cmd.left_count[CNT_W-1:0];
      right_origin <= cmd.right_count[CNT_W-1:0];
      goal_ticks   <= tgt_prod[DIST_W+GAIN_W-1:GAIN_FRAC_BITS];
    end
    if (take) begin
      job <= job_next;
    end
  end

endmodule

FILE: sv/sdpid_fifo.sv
`timescale 1ns / 1ps

module sdpid_fifo import sdpid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = count != (FIFO_AW+1)'(FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/sdpid_back.sv
`timescale 1ns / 1ps

module sdpid_back import sdpid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int WHOLE_W = OUT_Q_W - GAIN_FRAC_BITS;
  localparam logic signed [OUT_Q_W-1:0] ROUND_BIAS =
    OUT_Q_W'((64'sd1 <<< GAIN_FRAC_BITS) - 1);
  localparam logic signed [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'((64'sd1 <<< (SPD_W-1)) - 1);
  localparam logic signed [WHOLE_W-1:0] WHOLE_MIN = -WHOLE_MAX - WHOLE_W'(1);

  // Q value to motor command: truncate toward zero, then saturate
  function automatic logic signed [SPD_W-1:0] q_to_speed(input logic signed [OUT_Q_W-1:0] q);
    logic signed [OUT_Q_W-1:0] biased;
    logic signed [WHOLE_W-1:0] whole;
    biased = q[OUT_Q_W-1] ? q + ROUND_BIAS : q;
    whole  = biased[OUT_Q_W-1:GAIN_FRAC_BITS];
    if (whole > WHOLE_MAX) begin
      return WHOLE_MAX[SPD_W-1:0];
    end else if (whole < WHOLE_MIN) begin
      return WHOLE_MIN[SPD_W-1:0];
    end else begin
      return whole[SPD_W-1:0];
    end
  endfunction

  // pid state
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   last_error;

  logic                      adv;
  logic                      pop;
  logic signed [ERR_W:0]     sum_raw;
  logic signed [ERR_W:0]     lim_pos;
  logic signed [ERR_W:0]     sum_clamp;
  logic signed [DLT_W-1:0]   delta;

  // stage a: error terms
  logic                      a_valid;
  op_t                       a_op;
  logic                      a_moving;
  logic                      a_going_back;
  logic signed [ERR_W-1:0]   a_err;
  logic signed [SUM_W-1:0]   a_sum;
  logic signed [DLT_W-1:0]   a_delta;

  // stage b: products
  logic                      b_valid;
  op_t                       b_op;
  logic                      b_moving;
  logic signed [PROD_W-1:0]  b_p;
  logic signed [PROD_W-1:0]  b_i;
  logic signed [PROD_W-1:0]  b_d;
  logic signed [SPD_W-1:0]   b_base_l;
  logic signed [SPD_W:0]     b_base_r;

  // stage c: correction sum
  logic                      c_valid;
  op_t                       c_op;
  logic                      c_moving;
  logic signed [CTL_W-1:0]   c_ctl;
  logic signed [SPD_W-1:0]   c_base_l;
  logic signed [SPD_W:0]     c_base_r;

  logic signed [OUT_Q_W-1:0] left_q;
  logic signed [OUT_Q_W-1:0] right_q;
  res_t                      res_next;

  // whole pipeline moves when the output register can take a result
  assign adv       = !res_valid || res_ready;
  assign job_ready = adv;
  assign pop       = job_valid && adv;

  // integral update with clamp, derivative difference
  assign sum_raw = (ERR_W+1)'($signed(job.err)) + (ERR_W+1)'(error_sum);
  assign lim_pos = (ERR_W+1)'($signed({1'b0, cfg.integral_limit}));
  assign delta   = DLT_W'($signed(job.err)) - DLT_W'(last_error);

  always_comb begin
    if (sum_raw > lim_pos) begin
      sum_clamp = lim_pos;
    end else if (sum_raw < -lim_pos) begin
      sum_clamp = -lim_pos;
    end else begin
      sum_clamp = sum_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (pop) begin
      if (job.op == OP_START) begin
        error_sum  <= '0;
        last_error <= '0;
      end else if (job.op == OP_RUN) begin
        error_sum  <= sum_clamp[SUM_W-1:0];
        last_error <= job.err;
      end
    end
  end

  // stage valids and output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= pop;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      res_valid <= c_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      a_op         <= job.op;
      a_moving     <= job.moving;
      a_going_back <= job.going_back;
      a_err        <= job.err;
      a_sum        <= sum_clamp[SUM_W-1:0];
      a_delta      <= delta;

      b_op     <= a_op;
      b_moving <= a_moving;
      b_p      <= PROD_W'($signed({1'b0, cfg.gain_p_q16}) * a_err);
      b_i      <= PROD_W'($signed({1'b0, cfg.gain_i_dt_q16}) * a_sum);
      b_d      <= PROD_W'($signed({1'b0, cfg.gain_d_over_dt_q16}) * a_delta);
      b_base_l <= a_going_back ? cfg.backward_speed : cfg.forward_speed;
      b_base_r <= (SPD_W+1)'(a_going_back ? cfg.backward_speed : cfg.forward_speed)
                + (SPD_W+1)'(cfg.right_offset);

      c_op     <= b_op;
      c_moving <= b_moving;
      c_ctl    <= CTL_W'(b_p) + CTL_W'(b_i) + CTL_W'(b_d);
      c_base_l <= b_base_l;
      c_base_r <= b_base_r;

      res <= res_next;
    end
  end

  // motor commands from base speed and correction
  assign left_q  = (OUT_Q_W'(c_base_l) <<< GAIN_FRAC_BITS) - OUT_Q_W'(c_ctl);
  assign right_q = (OUT_Q_W'(c_base_r) <<< GAIN_FRAC_BITS) + OUT_Q_W'(c_ctl);

  always_comb begin
    res_next.brake  = c_op == OP_BRAKE;
    res_next.moving = c_moving;
    if (c_op == OP_RUN) begin
      res_next.left_motor  = q_to_speed(left_q);
      res_next.right_motor = q_to_speed(right_q);
    end else begin
      res_next.left_motor  = '0;
      res_next.right_motor = '0;
    end
  end

endmodule

FILE: sv/straight_drive_pid_controller.sv
`timescale 1ns / 1ps
// channel  direction  payload  handshake
// cmd      in         cmd_t    cmd_valid / cmd_ready
// res      out        res_t    res_valid / res_ready
// reg      in/out     32 bit   psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one transaction per cycle sustained while res_ready is held high, each cmd gives exactly one res
// each cmd passes the front register, the queue, then three back stages and the output register
// the front holds the move origins, target and run flag; the back holds the pid sums
// a four-entry queue sits between front and back, so cmd_ready drops only after it fills
// rst is synchronous, clears the run flag, pid sums, queue and all valid bits

module straight_drive_pid_controller import sdpid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  logic front_valid;
  logic front_ready;
  job_t front_job;
  logic queue_valid;
  logic queue_ready;
  job_t queue_job;

  // configuration registers
  sdpid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classify items and track the move
  sdpid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // decoupling queue
  sdpid_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_job)
  );

  // pid and motor command pipeline
  sdpid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .job       (queue_job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

FILE: sv/sdpid_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdpid_checker import sdpid_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // a braking result always ends the move
  `SDPID_ASSERT_IMPL(a_brake_ends_move, res_valid && res.brake, !res.moving, "brake with moving set")

  // no motor drive unless a move is in progress
  `SDPID_ASSERT_IMPL(a_idle_no_drive, res_valid && !res.moving, res.left_motor == '0 && res.right_motor == '0, "motor drive while idle")

  // a stalled result holds
  `SDPID_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

endmodule

bind straight_drive_pid_controller sdpid_checker u_sdpid_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sdpid_pkg::*;

  localparam int     HOLD_CYCLES = 60;
  localparam int     PHASES      = 8;
  localparam int     RAND_ITEMS  = 58;
  localparam longint Q_ONE       = longint'(1) <<< GAIN_FRAC_BITS;
  localparam longint ERR_MAX     = (longint'(1) <<< (ERR_W - 1)) - 1;
  localparam longint ERR_MIN     = -(longint'(1) <<< (ERR_W - 1));

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  cmd_t              cmd = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  straight_drive_pid_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // drive-controller mirror: register copy and move state
  cfg_t                 cfg_m;
  logic                 m_active = 1'b0;
  logic                 m_back = 1'b0;
  logic [CNT_W-1:0]     m_lorg = '0;
  logic [CNT_W-1:0]     m_rorg = '0;
  longint               m_target = 0;
  longint               m_esum = 0;
  longint               m_elast = 0;

  cmd_t pending_cmds[$];
  res_t wheel_cmds_due[$];

  int n_issued = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_moves = 0;
  int n_pid = 0;
  int n_brakes = 0;
  int n_clamps = 0;
  int n_writes = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_at = -1;
  int hold_left = 0;

  // Q16 control value to a saturated int16 motor command, truncating toward zero
  function automatic logic [SPD_W-1:0] q_to_speed(longint q);
    longint v;
    v = q / Q_ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SPD_W-1:0];
  endfunction

  // one command through the move/pid state, returns the motor outputs it causes
  function automatic res_t pid_drive_step(cmd_t c);
    res_t                r;
    longint              span, mag, ld, rd, la, ra, e, s, lim, ctl, base;
    logic [CNT_W-1:0]    ldiff, rdiff;
    r = '0;
    if (c.action == 1'b0) begin
      span = longint'($signed(c.move_mm));
      if (span != 0) begin
        mag = (span < 0) ? -span : span;
        m_esum = 0;
        m_elast = 0;
        m_lorg = c.left_count[CNT_W-1:0];
        m_rorg = c.right_count[CNT_W-1:0];
        m_target = (mag * longint'(cfg_m.ticks_per_mm_q16)) >>> GAIN_FRAC_BITS;
        m_back = (span < 0);
        m_active = 1'b1;
        n_moves++;
      end
    end else if (m_active) begin
      ldiff = c.left_count[CNT_W-1:0] - m_lorg;
      rdiff = c.right_count[CNT_W-1:0] - m_rorg;
      ld = longint'($signed(ldiff));
      rd = longint'($signed(rdiff));
      la = (ld < 0) ? -ld : ld;
      ra = (rd < 0) ? -rd : rd;
      if ((la + ra) / 2 >= m_target) begin
        m_active = 1'b0;
        r.brake = 1'b1;
        n_brakes++;
      end else begin
        lim = longint'(cfg_m.integral_limit);
        e = ld - rd;
        if (e > ERR_MAX) e = ERR_MAX;
        if (e < ERR_MIN) e = ERR_MIN;
        s = m_esum + e;
        if (s > lim || s < -lim) n_clamps++;
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        m_esum = s;
        ctl = longint'(cfg_m.gain_p_q16) * e
            + longint'(cfg_m.gain_i_dt_q16) * s
            + longint'(cfg_m.gain_d_over_dt_q16) * (e - m_elast);
        m_elast = e;
        base = m_back ? longint'($signed(cfg_m.backward_speed))
                      : longint'($signed(cfg_m.forward_speed));
        r.left_motor = q_to_speed(base * Q_ONE - ctl);
        r.right_motor = q_to_speed((base + longint'($signed(cfg_m.right_offset))) * Q_ONE + ctl);
        n_pid++;
      end
    end
    r.moving = m_active;
    return r;
  endfunction

  task automatic flag_result(string why, res_t want, res_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch (%s) at %0t: want l=%0d r=%0d brake=%0b moving=%0b", why, $time,
               $signed(want.left_motor), $signed(want.right_motor), want.brake, want.moving);
      $display("    got l=%0d r=%0d brake=%0b moving=%0b",
               $signed(got.left_motor), $signed(got.right_motor), got.brake, got.moving);
    end
  endtask

  // command driver: predicts each accepted transaction, then loads the next one
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        wheel_cmds_due.push_back(pid_drive_step(cmd));
        n_sent <= n_sent + 1;
      end
      if (!cmd_valid || cmd_ready) begin
        if (pending_cmds.size() != 0 &&
            (hold_left != 0 || $urandom_range(99) >= snd_idle_pct)) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by a chosen command transaction
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cmd_valid && cmd_ready && n_sent == hold_at) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each transaction against the oldest pending motor command
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (wheel_cmds_due.size() == 0) begin
          flag_result("unexpected", '0, res);
        end else begin
          want = wheel_cmds_due.pop_front();
          if (res.left_motor !== want.left_motor || res.right_motor !== want.right_motor ||
              res.brake !== want.brake || res.moving !== want.moving)
            flag_result("field", want, res);
        end
        n_checked <= n_checked + 1;
      end
      res_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_writes++;
    case (idx)
      REG_GAIN_P:       cfg_m.gain_p_q16 = val[GAIN_W-1:0];
      REG_GAIN_I:       cfg_m.gain_i_dt_q16 = val[GAIN_W-1:0];
      REG_GAIN_D:       cfg_m.gain_d_over_dt_q16 = val[GAIN_W-1:0];
      REG_INT_LIMIT:    cfg_m.integral_limit = val[GAIN_W-1:0];
      REG_TICKS_PER_MM: cfg_m.ticks_per_mm_q16 = val[GAIN_W-1:0];
      REG_FWD_SPEED:    cfg_m.forward_speed = val[SPD_W-1:0];
      REG_BWD_SPEED:    cfg_m.backward_speed = val[SPD_W-1:0];
      REG_RIGHT_OFFSET: cfg_m.right_offset = val[SPD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                           logic [GAIN_W-1:0] gd, logic [GAIN_W-1:0] lim,
                           logic [GAIN_W-1:0] tpm, logic [SPD_W-1:0] fwd,
                           logic [SPD_W-1:0] bwd, logic [SPD_W-1:0] ofs);
    reg_write(REG_GAIN_P, APB_DW'(gp));
    reg_write(REG_GAIN_I, APB_DW'(gi));
    reg_write(REG_GAIN_D, APB_DW'(gd));
    reg_write(REG_INT_LIMIT, APB_DW'(lim));
    reg_write(REG_TICKS_PER_MM, APB_DW'(tpm));
    reg_write(REG_FWD_SPEED, {{(APB_DW-SPD_W){fwd[SPD_W-1]}}, fwd});
    reg_write(REG_BWD_SPEED, {{(APB_DW-SPD_W){bwd[SPD_W-1]}}, bwd});
    reg_write(REG_RIGHT_OFFSET, {{(APB_DW-SPD_W){ofs[SPD_W-1]}}, ofs});
  endtask

  // gains spread over tiny, moderate and full-range values
  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(3))
      0:       return GAIN_W'($urandom_range(0, 255));
      1:       return GAIN_W'($urandom_range(0, 1 << 17));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic push_cmd(logic act, logic [DIST_W-1:0] span,
                          logic [CNT_FIELD_W-1:0] l, logic [CNT_FIELD_W-1:0] r);
    cmd_t c;
    c.action = act;
    c.move_mm = span;
    c.left_count = l;
    c.right_count = r;
    pending_cmds.push_back(c);
    n_issued++;
  endtask

  // a start followed by ticks that walk both wheels toward the target with jitter
  task automatic add_move();
    int                      mag, n, stp, jl, jr, dir;
    logic [DIST_W-1:0]       span;
    logic [CNT_FIELD_W-1:0]  lp, rp;
    longint                  tgt;
    case ($urandom_range(9))
      0:       mag = $urandom_range(1, 32767);
      1, 2:    mag = $urandom_range(1, 5000);
      default: mag = $urandom_range(1, 200);
    endcase
    dir = $urandom_range(1) ? 1 : -1;
    if ($urandom_range(49) == 0) begin
      dir = -1;
      mag = 32768;
    end
    span = DIST_W'(dir * mag);
    tgt = (longint'(mag) * longint'(cfg_m.ticks_per_mm_q16)) >>> GAIN_FRAC_BITS;
    n = $urandom_range(1, 12);
    stp = int'(tgt / n) + 1;
    lp = $urandom;
    rp = $urandom;
    push_cmd(1'b0, span, lp, rp);
    // now and then the wheels travel the wrong way
    if ($urandom_range(9) == 0) dir = -dir;
    for (int k = 0; k < n + 1; k++) begin
      jl = $urandom_range(0, stp / 4 + 3);
      jr = $urandom_range(0, stp / 4 + 3);
      lp = lp + dir * (stp - stp / 8 + jl);
      rp = rp + dir * (stp - stp / 8 + jr);
      push_cmd(1'b1, DIST_W'($urandom), lp, rp);
      // abandoned move, the next start restarts it
      if ($urandom_range(19) == 0) break;
    end
  endtask

  task automatic add_directed();
    longint t;
    // tick while idle, then a zero-distance start
    push_cmd(1'b1, 16'h7FFF, 32'hFFFF_FFFF, 32'h0);
    push_cmd(1'b0, 16'h0000, 32'h0000_1234, 32'h0000_5678);
    // start right below the counter wrap, ticks wrap around
    push_cmd(1'b0, 16'd100, 32'hFFFF_FFF0, 32'h0000_0010);
    push_cmd(1'b1, 16'h8000, 32'h0000_0022, 32'h0000_0038);
    push_cmd(1'b1, 16'h0000, 32'h0000_0086, 32'h0000_00BA);
    push_cmd(1'b1, 16'hFFFF, 32'hFFFF_FFDC, 32'h0000_013C);
    // zero distance while moving, then restart backward at full magnitude
    push_cmd(1'b0, 16'h0000, 32'h0, 32'h0);
    push_cmd(1'b0, 16'h8000, 32'h0, 32'h0);
    push_cmd(1'b1, 16'h0000, 32'hFFFF_FC18, 32'hFFFF_FC22);
    // huge travel brakes, then tick after brake
    push_cmd(1'b1, 16'h0000, 32'h8000_0000, 32'h0);
    push_cmd(1'b1, 16'h0000, 32'h5, 32'h7);
    // longest forward move, large errors clamp the integral and saturate speeds
    push_cmd(1'b0, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_cmd(1'b1, 16'h0000, 32'h7FFF_FFFF + 40000, 32'h8000_0000 + 10000);
    push_cmd(1'b1, 16'h0000, 32'h7FFF_FFFF + 10000, 32'h8000_0000 + 40000);
    // one tick short of the target, then exactly on it
    t = (longint'(32767) * longint'(cfg_m.ticks_per_mm_q16)) >>> GAIN_FRAC_BITS;
    push_cmd(1'b1, 16'h0000, CNT_FIELD_W'(32'h7FFF_FFFF + 2 * t - 1), 32'h8000_0000);
    push_cmd(1'b1, 16'h0000, CNT_FIELD_W'(32'h7FFF_FFFF + 2 * t - 1), 32'h8000_0001);
    // shortest move
    push_cmd(1'b0, 16'd1, 32'hAAAA_AAAA, 32'h5555_5555);
    push_cmd(1'b1, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push_cmd(1'b1, 16'hAAAA, 32'hAAAA_AAB6, 32'h5555_5555);
  endtask

  task automatic wait_results();
    @(negedge clk);
    while (n_checked != n_issued) @(negedge clk);
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // phases of register settings and idle patterns
  initial begin
    int phase_base;
    cfg_m.gain_p_q16 = 24'd78643;
    cfg_m.gain_i_dt_q16 = 24'd26;
    cfg_m.gain_d_over_dt_q16 = 24'd1638400;
    cfg_m.integral_limit = 24'd25000;
    cfg_m.ticks_per_mm_q16 = 24'd416601;
    cfg_m.forward_speed = 16'sd700;
    cfg_m.backward_speed = -16'sd800;
    cfg_m.right_offset = 16'sd100;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                     16'h7FFF, 16'h8000, 16'h7FFF);
        2: write_all(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 16'h8000, 16'h7FFF, 16'h8000);
        7: write_all(24'd78643, 24'd26, 24'd1638400, 24'd25000, 24'd416601,
                     16'd700, -16'sd800, 16'd100);
        default: write_all(rand_gain(), rand_gain(), rand_gain(),
                           GAIN_W'($urandom_range(0, 1 << ($urandom_range(1, 24) - 1))),
                           GAIN_W'($urandom_range(0, 1 << 20)),
                           SPD_W'($urandom), SPD_W'($urandom), SPD_W'($urandom));
      endcase
      @(negedge clk);
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 60; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 60; end
        default: begin snd_idle_pct = 23; rcv_stall_pct = 23; end
      endcase
      hold_at = n_issued + 25;
      if (p == 0) begin
        add_directed();
        // sender pauses until every motor command has come back
        wait_results();
      end
      phase_base = n_issued;
      while (n_issued < phase_base + RAND_ITEMS) begin
        case ($urandom_range(9))
          0: push_cmd(1'(($urandom_range(1))), DIST_W'($urandom), $urandom, $urandom);
          1: push_cmd(1'b0, '0, $urandom, $urandom);
          default: add_move();
        endcase
      end
      wait_results();
    end

    repeat (20) @(posedge clk);
    if (wheel_cmds_due.size() != 0) n_err++;
    $display("ran %0d commands over %0d settings (%0d register writes)",
             n_issued, PHASES, n_writes);
    $display("moves %0d, pid updates %0d, brakes %0d, integral clamps %0d, errors %0d",
             n_moves, n_pid, n_brakes, n_clamps, n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
